/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and result codes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_REJECT = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_EMPTY  = 2'd3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam int TYPE_BITS = 8;
  localparam int PRIO_BITS = 32;

  typedef struct packed {
    logic id_eq;
    logic prio_gt;
  } cmp_res_t;

endpackage

/* rtl/spq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/spq_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cmp
// Shared compare unit: identifier match and signed priority order of one
// stored entry against the pending request.
// ----------------------------------------------------------------------------
module spq_cmp #(
  parameter int ID_BITS = 16
) (
  input  logic [ID_BITS-1:0]           ent_id,
  input  logic [spq_pkg::PRIO_BITS-1:0] ent_prio,
  input  logic [ID_BITS-1:0]           req_id,
  input  logic [spq_pkg::PRIO_BITS-1:0] req_prio,
  output spq_pkg::cmp_res_t            res
);

  always_comb begin
    res.id_eq   = (ent_id == req_id);
    res.prio_gt = ($signed(ent_prio) > $signed(req_prio));
  end

endmodule

/* rtl/stable_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue, lowest priority first, equal priorities in order.
// ----------------------------------------------------------------------------
// Input channel (in_*): in_tuser selects insert (0) or remove (1); in_tdata
// carries identifier, type and signed priority. Output channel (out_*): one
// result transaction per input transaction, status in out_tuser, removed
// entry and the count after the operation in out_tdata.
// Entries sit in a circular buffer in one RAM; a single compare unit walks
// it under a sequencer that reads each entry and then checks it.
// Insert: accept, a scan for duplicates and the insert point, a read and a
// write per entry moved back, then the write of the new entry and the result.
// A duplicate or a full queue ends after the scan with the result.
// A rejected null identifier goes from accept straight to the result.
// Remove: accept, head read, data return, result. Empty remove: accept and
// result.
// in_tready is high only while the sequencer is idle; a finished result
// waits in the output register while the next transaction is taken, and a
// stalled receiver holds the sequencer in its result state.
// Reset empties the queue at once; the RAM content needs no clearing.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int DEPTH   = 32,
  parameter int ID_BITS = 16,
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW  = $clog2(DEPTH + 1),
  localparam int EW  = ID_BITS + spq_pkg::TYPE_BITS + spq_pkg::PRIO_BITS,
  localparam int IDW = ((EW + 7) / 8) * 8,
  localparam int ODW = ((EW + CW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [IDW-1:0] in_tdata,   // item_id, item_type, priority_req, zero pad
  input  logic           in_tuser,   // kind
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [ODW-1:0] out_tdata,  // out_item_id, out_item_type, out_priority, count, pad
  output logic [1:0]     out_tuser   // status
);

  localparam int TB = spq_pkg::TYPE_BITS;
  localparam int PB = spq_pkg::PRIO_BITS;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN_RD = 4'd1;
  localparam logic [3:0] S_SCAN_CK = 4'd2;
  localparam logic [3:0] S_SH_RD   = 4'd3;
  localparam logic [3:0] S_SH_WR   = 4'd4;
  localparam logic [3:0] S_INS_WR  = 4'd5;
  localparam logic [3:0] S_RM_RD   = 4'd6;
  localparam logic [3:0] S_RM_WT   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic found_r, found_nxt;
  logic dup_r, dup_nxt;

  logic [ID_BITS-1:0] req_id_r, req_id_nxt;
  logic [TB-1:0] req_type_r, req_type_nxt;
  logic [PB-1:0] req_prio_r, req_prio_nxt;

  spq_pkg::status_t res_status_r, res_status_nxt;
  logic [ID_BITS-1:0] res_id_r, res_id_nxt;
  logic [TB-1:0] res_type_r, res_type_nxt;
  logic [PB-1:0] res_prio_r, res_prio_nxt;

  logic out_valid_r, out_valid_nxt;
  spq_pkg::status_t out_status_r, out_status_nxt;
  logic [ID_BITS-1:0] out_id_r, out_id_nxt;
  logic [TB-1:0] out_type_r, out_type_nxt;
  logic [PB-1:0] out_prio_r, out_prio_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [ID_BITS-1:0] ent_id;
  logic [TB-1:0] ent_type;
  logic [PB-1:0] ent_prio;
  spq_pkg::cmp_res_t cmp_res;

  logic [CW-1:0] idx_dec;
  logic in_fire;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] lidx);
    logic [AW+1:0] s;
    s = (AW+2)'(head) + (AW+2)'(lidx);
    if (s >= (AW+2)'(DEPTH)) begin
      s = s - (AW+2)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign ent_id   = ram_rdata[ID_BITS-1:0];
  assign ent_type = ram_rdata[ID_BITS+TB-1:ID_BITS];
  assign ent_prio = ram_rdata[EW-1:ID_BITS+TB];
  assign idx_dec  = idx_r - CW'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = ODW'({out_count_r, out_prio_r, out_type_r, out_id_r});

  spq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  spq_cmp #(
    .ID_BITS(ID_BITS)
  ) u_cmp (
    .ent_id  (ent_id),
    .ent_prio(ent_prio),
    .req_id  (req_id_r),
    .req_prio(req_prio_r),
    .res     (cmp_res)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    dup_nxt        = dup_r;
    req_id_nxt     = req_id_r;
    req_type_nxt   = req_type_r;
    req_prio_nxt   = req_prio_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_type_nxt   = res_type_r;
    res_prio_nxt   = res_prio_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_type_nxt   = out_type_r;
    out_prio_nxt   = out_prio_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_id_nxt     = in_tdata[ID_BITS-1:0];
          req_type_nxt   = in_tdata[ID_BITS+TB-1:ID_BITS];
          req_prio_nxt   = in_tdata[EW-1:ID_BITS+TB];
          res_status_nxt = spq_pkg::ST_OK;
          res_id_nxt     = '0;
          res_type_nxt   = '0;
          res_prio_nxt   = '0;
          idx_nxt        = '0;
          pos_nxt        = occ_r;
          found_nxt      = 1'b0;
          dup_nxt        = 1'b0;
          if (in_tuser == spq_pkg::KIND_REMOVE) begin
            if (occ_r == '0) begin
              res_status_nxt = spq_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_RM_RD;
            end
          end else if (in_tdata[ID_BITS-1:0] == '0) begin
            res_status_nxt = spq_pkg::ST_REJECT;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx_r == occ_r) begin
          if (dup_r) begin
            res_status_nxt = spq_pkg::ST_REJECT;
            state_nxt      = S_DONE;
          end else if (occ_r == CW'(DEPTH)) begin
            res_status_nxt = spq_pkg::ST_FULL;
            state_nxt      = S_DONE;
          end else if (occ_r > pos_r) begin
            state_nxt = S_SH_RD;
          end else begin
            state_nxt = S_INS_WR;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_r, idx_r);
          state_nxt = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (cmp_res.id_eq) begin
          dup_nxt = 1'b1;
        end
        if (!found_r && cmp_res.prio_gt) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SCAN_RD;
      end
      S_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = phys(head_r, idx_dec);
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, idx_r);
        ram_wdata = ram_rdata;
        idx_nxt   = idx_dec;
        if (idx_dec > pos_r) begin
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, pos_r);
        ram_wdata = {req_prio_r, req_type_r, req_id_r};
        occ_nxt   = occ_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_RM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = head_r;
        state_nxt = S_RM_WT;
      end
      S_RM_WT: begin
        res_id_nxt   = ent_id;
        res_type_nxt = ent_type;
        res_prio_nxt = ent_prio;
        head_nxt     = phys(head_r, CW'(1));
        occ_nxt      = occ_r - CW'(1);
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_type_nxt   = res_type_r;
          out_prio_nxt   = res_prio_r;
          out_count_nxt  = occ_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      found_r     <= found_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_id_r     <= req_id_nxt;
    req_type_r   <= req_type_nxt;
    req_prio_r   <= req_prio_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_type_r   <= res_type_nxt;
    res_prio_r   <= res_prio_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_type_r   <= out_type_nxt;
    out_prio_r   <= out_prio_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stable priority queue. A directed table covers
// the empty, null, duplicate and tie cases and the priority extremes. Random
// bursts of inserts and removes follow, filling the queue past full and
// draining it past empty. A shadow queue predicts every result that the table
// does not give. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH   = 32;
  localparam int ID_BITS = 16;
  localparam int LIMIT   = 1500000;
  localparam int N_RAND  = 1650;
  localparam int N_DIR   = 22;

  typedef struct packed {
    logic        kind;
    logic [15:0] id;
    logic [7:0]  itype;
    logic [31:0] prio;
  } op_t;

  typedef struct packed {
    spq_pkg::status_t status;
    logic [15:0]      id;
    logic [7:0]       itype;
    logic [31:0]      prio;
    logic [5:0]       count;
  } res_t;

  typedef struct packed {
    logic given;
    op_t  op;
    res_t res;
  } row_t;

  localparam row_t DIRECTED [N_DIR] = '{
    '{1'b1, '{spq_pkg::KIND_REMOVE, 16'h0000, 8'h00, 32'h0000_0000},
            '{spq_pkg::ST_EMPTY,  16'h0000, 8'h00, 32'h0000_0000, 6'd0}},
    '{1'b1, '{spq_pkg::KIND_INSERT, 16'h0000, 8'hFF, 32'h7FFF_FFFF},
            '{spq_pkg::ST_REJECT, 16'h0000, 8'h00, 32'h0000_0000, 6'd0}},
    '{1'b1, '{spq_pkg::KIND_INSERT, 16'hFFFF, 8'hFF, 32'h7FFF_FFFF},
            '{spq_pkg::ST_OK,     16'h0000, 8'h00, 32'h0000_0000, 6'd1}},
    '{1'b1, '{spq_pkg::KIND_INSERT, 16'hFFFF, 8'h00, 32'h0000_0000},
            '{spq_pkg::ST_REJECT, 16'h0000, 8'h00, 32'h0000_0000, 6'd1}},
    '{1'b1, '{spq_pkg::KIND_INSERT, 16'h0001, 8'h00, 32'h8000_0000},
            '{spq_pkg::ST_OK,     16'h0000, 8'h00, 32'h0000_0000, 6'd2}},
    '{1'b0, '{spq_pkg::KIND_INSERT, 16'h0002, 8'h5A, 32'h8000_0000}, '0},
    '{1'b0, '{spq_pkg::KIND_INSERT, 16'h0003, 8'hA5, 32'h0000_0000}, '0},
    '{1'b0, '{spq_pkg::KIND_INSERT, 16'h0004, 8'h01, 32'h0000_0000}, '0},
    '{1'b0, '{spq_pkg::KIND_INSERT, 16'h0005, 8'h02, 32'hFFFF_FFFF}, '0},
    '{1'b0, '{spq_pkg::KIND_INSERT, 16'h0006, 8'h03, 32'h0000_0001}, '0},
    '{1'b0, '{spq_pkg::KIND_INSERT, 16'h0000, 8'h04, 32'h0000_0002}, '0},
    '{1'b0, '{spq_pkg::KIND_INSERT, 16'h0003, 8'h05, 32'h8000_0000}, '0},
    '{1'b0, '{spq_pkg::KIND_REMOVE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, '0},
    '{1'b0, '{spq_pkg::KIND_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, '0},
    '{1'b0, '{spq_pkg::KIND_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, '0},
    '{1'b0, '{spq_pkg::KIND_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, '0},
    '{1'b0, '{spq_pkg::KIND_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, '0},
    '{1'b0, '{spq_pkg::KIND_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, '0},
    '{1'b0, '{spq_pkg::KIND_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, '0},
    '{1'b1, '{spq_pkg::KIND_REMOVE, 16'h0000, 8'h00, 32'h0000_0000},
            '{spq_pkg::ST_EMPTY,  16'h0000, 8'h00, 32'h0000_0000, 6'd0}},
    '{1'b0, '{spq_pkg::KIND_INSERT, 16'h8000, 8'h80, 32'h8000_0000}, '0},
    '{1'b0, '{spq_pkg::KIND_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, '0}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  int send_idle  = 0;
  int recv_stall = 0;
  int fails      = 0;
  int cycles     = 0;

  logic [15:0] sq_id   [DEPTH];
  logic [7:0]  sq_type [DEPTH];
  logic [31:0] sq_prio [DEPTH];
  int          sq_count = 0;

  res_t pending_results[$];

  stable_priority_queue #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t queue_apply(op_t op);
    res_t r;
    bit   dup;
    int   pos;
    r   = '0;
    dup = 1'b0;
    r.status = spq_pkg::ST_OK;
    if (op.kind == spq_pkg::KIND_INSERT) begin
      for (int i = 0; i < sq_count; i++) begin
        if (sq_id[i] == op.id) dup = 1'b1;
      end
      if (op.id == '0 || dup) begin
        r.status = spq_pkg::ST_REJECT;
      end else if (sq_count >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < sq_count && $signed(sq_prio[pos]) <= $signed(op.prio)) pos++;
        for (int i = sq_count; i > pos; i--) begin
          sq_id[i]   = sq_id[i-1];
          sq_type[i] = sq_type[i-1];
          sq_prio[i] = sq_prio[i-1];
        end
        sq_id[pos]   = op.id;
        sq_type[pos] = op.itype;
        sq_prio[pos] = op.prio;
        sq_count++;
      end
    end else if (sq_count == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.id    = sq_id[0];
      r.itype = sq_type[0];
      r.prio  = sq_prio[0];
      for (int i = 1; i < sq_count; i++) begin
        sq_id[i-1]   = sq_id[i];
        sq_type[i-1] = sq_type[i];
        sq_prio[i-1] = sq_prio[i];
      end
      sq_count--;
    end
    r.count = 6'(sq_count);
    return r;
  endfunction

  function automatic op_t rand_op(logic kind);
    op_t op;
    int  p;
    op.kind  = kind;
    op.itype = 8'($urandom_range(0, 255));
    p = $urandom_range(0, 99);
    if (p < 4) begin
      op.id = '0;
    end else if (p < 20 && sq_count > 0) begin
      op.id = sq_id[$urandom_range(0, sq_count - 1)];
    end else begin
      op.id = 16'($urandom_range(1, 65535));
    end
    p = $urandom_range(0, 99);
    if (p < 10) begin
      op.prio = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else if (p < 40) begin
      op.prio = 32'($urandom_range(0, 6)) - 32'd3;
    end else begin
      op.prio = $urandom;
    end
    return op;
  endfunction

  task automatic send_op(input op_t op, input logic given, input res_t given_res);
    res_t pred;
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {op.prio, op.itype, op.id};
    in_tuser  <= op.kind;
    do @(posedge clk); while (!in_tready);
    pred = queue_apply(op);
    pending_results.push_back(given ? given_res : pred);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (fails < 100) $display("tb: mismatch on %s: got %0h, want %0h", what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected transaction", {30'd0, out_tuser}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.status)
          note_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[15:0] != want.id)
          note_mismatch("out_item_id", 32'(out_tdata[15:0]), 32'(want.id));
        if (out_tdata[23:16] != want.itype)
          note_mismatch("out_item_type", 32'(out_tdata[23:16]), 32'(want.itype));
        if (out_tdata[55:24] != want.prio)
          note_mismatch("out_priority", out_tdata[55:24], want.prio);
        if (out_tdata[61:56] != want.count)
          note_mismatch("count", 32'(out_tdata[61:56]), 32'(want.count));
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int   idle_tab [4];
    int   stall_tab [4];
    int   n;
    int   len;
    int   mode;
    op_t  op;
    idle_tab  = '{0, 57, 0, 36};
    stall_tab = '{0, 0, 57, 36};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      send_op(DIRECTED[r].op, DIRECTED[r].given, DIRECTED[r].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = idle_tab[ph];
      recv_stall = stall_tab[ph];
      n = 0;
      while (n < N_RAND / 4) begin
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
          len = $urandom_range(20, 40);
        end else if (mode < 6) begin
          len = $urandom_range(10, 40);
        end else begin
          len = $urandom_range(10, 30);
        end
        for (int k = 0; k < len; k++) begin
          if (mode < 4) begin
            op = rand_op(spq_pkg::KIND_INSERT);
          end else if (mode < 6) begin
            op = rand_op(spq_pkg::KIND_REMOVE);
          end else begin
            op = rand_op(($urandom_range(0, 99) < 55) ? spq_pkg::KIND_INSERT
                                                      : spq_pkg::KIND_REMOVE);
          end
          send_op(op, 1'b0, '0);
          n++;
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_cmp.sv
rtl/stable_priority_queue.sv
bench/tb.sv
